>>> rtl/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

  // Coordinate width; the error term and increments scale with it.
  localparam int COORD_WIDTH    = 9;
  localparam int COLOR_WIDTH    = 24;
  localparam int ERR_WIDTH      = COORD_WIDTH + 3;
  localparam int STRAIGHT_WIDTH = COORD_WIDTH + 2;

  typedef logic [COORD_WIDTH-1:0]           coord_t;
  typedef logic [COLOR_WIDTH-1:0]           color_t;
  typedef logic signed [ERR_WIDTH-1:0]      err_t;
  typedef logic [STRAIGHT_WIDTH-1:0]        straight_t;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef struct packed {
    op_t    operation;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t line_color;
  } req_t;

  typedef struct packed {
    logic   valid_res;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last;
  } res_t;

  // Walking state of one line.
  typedef struct packed {
    logic      steep;
    logic      minor_down;
    coord_t    major_pos;
    coord_t    minor_pos;
    coord_t    major_stop;
    err_t      error_term;
    straight_t inc_straight;
    err_t      inc_diagonal;
  } line_t;

endpackage

`default_nettype wire

>>> rtl/line_pixel_generator.sv
// Bresenham line rasterizer for all octants, one pixel per request beat.
//
// Request channel (req_valid, req_stall, req): a beat with operation
// OP_START loads two endpoints and a color and yields the first pixel of
// the line. A beat with OP_ADVANCE yields the next pixel; the final pixel
// carries last = 1. An advance with no line in progress yields a result
// beat with valid_res = 0 and all other fields zero. A start abandons any
// line in progress.
// Result channel (res_valid, res_stall, res): exactly one result beat per
// request beat, in order.
// The result of an accepted request beat is registered and shows from the
// next cycle on. Throughput is one beat per cycle while the receiver does
// not stall, set by the single result register; the line setup and the
// error-term step are combinational, ahead of the result and line registers.
// When the receiver stalls, the result register holds its beat and the
// request side stalls in the same cycle; it takes a new beat as soon as
// the held one leaves.
// Reset (rst, synchronous) empties the result register and ends any line.
`default_nettype none

module line_pixel_generator (
  input  var logic          clk,
  input  var logic          rst,
  input  var logic          req_valid,
  output logic              req_stall,
  input  var lpg_pkg::req_t req,
  output logic              res_valid,
  input  var logic          res_stall,
  output lpg_pkg::res_t     res
);

  localparam int EXT_WIDTH = lpg_pkg::ERR_WIDTH - lpg_pkg::STRAIGHT_WIDTH;

  // Line state.
  logic            active;
  lpg_pkg::line_t  line;
  lpg_pkg::color_t held_color;

  lpg_pkg::line_t  setup_line;
  lpg_pkg::line_t  cur;
  lpg_pkg::line_t  line_next;
  lpg_pkg::color_t cur_color;
  lpg_pkg::res_t   res_next;
  logic            accept;
  logic            is_start;
  logic            emit;
  logic            fin;

  lpg_setup u_setup (
    .x_start (req.x_start),
    .y_start (req.y_start),
    .x_end   (req.x_end),
    .y_end   (req.y_end),
    .line    (setup_line)
  );

  // The result register frees up in the cycle its beat is taken.
  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;
  assign is_start  = req.operation == lpg_pkg::OP_START;

  always_comb begin
    // A start walks from its freshly set-up line; an advance from the held one.
    cur       = is_start ? setup_line : line;
    cur_color = is_start ? req.line_color : held_color;
    emit      = is_start || active;
    fin       = cur.major_pos == cur.major_stop;

    // One Bresenham step after emitting the current pixel.
    line_next = cur;
    if (cur.error_term > 0) begin
      line_next.minor_pos  = cur.minor_down ? cur.minor_pos - lpg_pkg::coord_t'(1)
                                            : cur.minor_pos + lpg_pkg::coord_t'(1);
      line_next.error_term = cur.error_term + cur.inc_diagonal;
    end else begin
      line_next.error_term = cur.error_term
                           + $signed({{EXT_WIDTH{1'b0}}, cur.inc_straight});
    end
    line_next.major_pos = cur.major_pos + lpg_pkg::coord_t'(1);

    res_next = '0;
    if (emit) begin
      res_next.valid_res   = 1'b1;
      res_next.pixel_x     = cur.steep ? cur.minor_pos : cur.major_pos;
      res_next.pixel_y     = cur.steep ? cur.major_pos : cur.minor_pos;
      res_next.pixel_color = cur_color;
      res_next.last        = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (accept && emit) begin
        active <= !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
      if (emit) begin
        line <= line_next;
      end
      if (is_start) begin
        held_color <= req.line_color;
      end
    end
  end

`ifndef ASSERT_OFF
  // An advance with no line in progress gives an empty result.
  assert property (@(posedge clk) disable iff (rst)
    accept && req.operation == lpg_pkg::OP_ADVANCE && !active
    |=> res_valid && !res.valid_res && !active)
    else $error("advance without a line did not give an empty result");

  // The first pixel of a line is one of its endpoints.
  assert property (@(posedge clk) disable iff (rst)
    accept && req.operation == lpg_pkg::OP_START
    |=> res.valid_res
        && ((res.pixel_x == $past(req.x_start) && res.pixel_y == $past(req.y_start))
         || (res.pixel_x == $past(req.x_end) && res.pixel_y == $past(req.y_end))))
    else $error("first pixel is not an endpoint");

  // The line ends exactly when its final pixel is emitted.
  assert property (@(posedge clk) disable iff (rst)
    accept && !(req.operation == lpg_pkg::OP_ADVANCE && !active)
    |=> res.last == !active)
    else $error("last flag and line activity disagree");
`endif

endmodule

`default_nettype wire

>>> rtl/lpg_setup.sv
`default_nettype none

// Turns two endpoints into the initial walking state of a line.
module lpg_setup (
  input  var lpg_pkg::coord_t x_start,
  input  var lpg_pkg::coord_t y_start,
  input  var lpg_pkg::coord_t x_end,
  input  var lpg_pkg::coord_t y_end,
  output lpg_pkg::line_t      line
);

  localparam int EXT_WIDTH = lpg_pkg::ERR_WIDTH - lpg_pkg::COORD_WIDTH;

  lpg_pkg::coord_t adx, ady;
  lpg_pkg::coord_t a_maj, a_min, b_maj, b_min;
  lpg_pkg::coord_t dmaj, dmin;
  logic            steep, swap;
  lpg_pkg::coord_t maj0, min0, maj1, min1;
  lpg_pkg::err_t   dmaj_ext, dmin2_ext, dmaj2_ext;

  always_comb begin
    adx = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
    ady = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
    // Equal spans, including a single point, take the steep case.
    steep = !(ady < adx);

    a_maj = steep ? y_start : x_start;
    a_min = steep ? x_start : y_start;
    b_maj = steep ? y_end   : x_end;
    b_min = steep ? x_end   : y_end;

    // Order the endpoints so that the major coordinate counts up.
    swap = a_maj > b_maj;
    maj0 = swap ? b_maj : a_maj;
    min0 = swap ? b_min : a_min;
    maj1 = swap ? a_maj : b_maj;
    min1 = swap ? a_min : b_min;

    dmaj = steep ? ady : adx;
    dmin = steep ? adx : ady;

    dmaj_ext  = $signed({{EXT_WIDTH{1'b0}}, dmaj});
    dmaj2_ext = $signed({{(EXT_WIDTH-1){1'b0}}, dmaj, 1'b0});
    dmin2_ext = $signed({{(EXT_WIDTH-1){1'b0}}, dmin, 1'b0});

    line.steep        = steep;
    line.minor_down   = min1 < min0;
    line.major_pos    = maj0;
    line.minor_pos    = min0;
    line.major_stop   = maj1;
    line.error_term   = dmin2_ext - dmaj_ext;
    line.inc_straight = {1'b0, dmin, 1'b0};
    line.inc_diagonal = dmin2_ext - dmaj2_ext;
  end

endmodule

`default_nettype wire
